// ----- rtl/lhrb_pkg.sv -----
// Package with shared constants and types for the lattice Hamiltonian row builder.
package lhrb_pkg;
   localparam int TableDepthDefault = 4096;
   localparam int MaxSitesDefault = 32;
   localparam int WordWidth = 32;
   localparam int ValueWidth = 24;
   localparam int IndexWidth = 34;
   localparam int OutValueWidth = 29;
   localparam int CsrDataWidth = 34;
   localparam int CsrIndexWidth = 3;

   typedef enum logic [1:0] {
      CMD_LOAD_WORD = 2'd0,
      CMD_PROCESS = 2'd1,
      CMD_LOAD_ONSITE = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_DIAGONAL = 2'd0,
      KIND_LOCAL_HOP = 2'd1,
      KIND_REMOTE_HOP = 2'd2
   } kind_type;

   localparam logic [CsrIndexWidth-1:0] CSR_SITE_COUNT = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_LOCAL_COUNT = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_GLOBAL_OFFSET = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_HOP_AMPLITUDE = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_INTERACTION = 3'd4;
endpackage

// ----- rtl/lhrb_req_if.sv -----
// Request and response channel interfaces of the row builder.
interface lhrb_req_if;
   logic valid;
   logic ready;
   logic [1:0] cmd;
   logic [11:0] entry_index;
   logic [31:0] basis_word;
   logic signed [23:0] onsite_value;
   modport source (output valid, cmd, entry_index, basis_word, onsite_value, input ready);
   modport sink (input valid, cmd, entry_index, basis_word, onsite_value, output ready);
endinterface

interface lhrb_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] entry_kind;
   logic [33:0] row_index;
   logic [33:0] col_index;
   logic [31:0] neighbour_word;
   logic signed [28:0] entry_value;
   logic last;
   modport source (output valid, entry_kind, row_index, col_index, neighbour_word,
      entry_value, last, input ready);
   modport sink (input valid, entry_kind, row_index, col_index, neighbour_word,
      entry_value, last, output ready);
endinterface

// ----- rtl/lattice_hamiltonian_row_builder.sv -----
// Top level of the lattice Hamiltonian row builder.
// A load request is taken in the idle state. A process request reads its row, then visits
// each site in turn; for each hop it searches the table by halving and emits a hop entry,
// and the row ends with the diagonal entry. Waits on the response handshake stall the row,
// and the next request is taken only after the diagonal entry has been emitted.
// Reset is synchronous, active high; it resets the state, the response valid and the CSR registers, not memories.
module lattice_hamiltonian_row_builder
   import lhrb_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int MAX_SITES = MaxSitesDefault
) (
   input logic clock,
   input logic reset,
   lhrb_req_if.sink req,
   lhrb_rsp_if.source rsp,
   input logic csr_write_enable,
   input logic [CsrIndexWidth-1:0] csr_index,
   input logic [CsrDataWidth-1:0] csr_write_data
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int LW = $clog2(TABLE_DEPTH + 1);
   localparam int SW = $clog2(MAX_SITES);
   localparam int SCW = $clog2(MAX_SITES + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_ROW_READ, ST_ROW_WAIT, ST_SITE, ST_PROBE, ST_PROBE_WAIT, ST_CMP,
      ST_EMIT, ST_DIAG, ST_DIAG_EMIT
   } state_type;

   logic [WordWidth-1:0] basis_mem [TABLE_DEPTH];
   logic [ValueWidth-1:0] onsite_mem [MAX_SITES];
   logic [WordWidth-1:0] mem_rdata_ff;
   logic [AW-1:0] mem_raddr;
   logic [ValueWidth-1:0] onsite_rdata_ff;

   logic [5:0] site_count_ff;
   logic [12:0] local_count_ff;
   logic [IndexWidth-1:0] global_offset_ff;
   logic signed [ValueWidth-1:0] hop_ff, inter_ff;

   state_type state_ff;
   logic [WordWidth-1:0] word_ff, nw_ff;
   logic [SW-1:0] site_ff;
   logic [SCW-1:0] sites_ff;
   logic [LW-1:0] len_ff, lo_ff, srch_ff, mid_ff;
   logic [IndexWidth-1:0] col_ff;
   logic signed [OutValueWidth+4:0] diag_ff;
   logic found_ff;
   logic [LW-1:0] pos_ff;

   logic [LW-1:0] eff_len;
   logic [SCW-1:0] eff_sites;
   logic [SW-1:0] next_site;
   logic b0, b1;
   logic [LW-1:0] mid_c;

   assign eff_len = ({{(32-13){1'b0}}, local_count_ff} > TABLE_DEPTH) ?
      LW'(TABLE_DEPTH) : LW'(local_count_ff);
   always_comb begin
      if (site_count_ff < 6'd2) eff_sites = SCW'(2);
      else if ({26'd0, site_count_ff} > MAX_SITES) eff_sites = SCW'(MAX_SITES);
      else eff_sites = SCW'(site_count_ff);
   end
   assign next_site = (SCW'(site_ff) + SCW'(1) == sites_ff) ? '0 : SW'(site_ff + 1'b1);
   assign b0 = word_ff[site_ff];
   assign b1 = word_ff[next_site];
   assign mid_c = srch_ff >> 1;

   always_comb begin
      mem_raddr = AW'(lo_ff + mid_c);
      if (state_ff == ST_IDLE) mem_raddr = AW'(req.entry_index);
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready && req.cmd == CMD_LOAD_WORD
          && {20'd0, req.entry_index} < TABLE_DEPTH)
         basis_mem[AW'(req.entry_index)] <= req.basis_word;
      else
         mem_rdata_ff <= basis_mem[mem_raddr];
      if (req.valid && req.ready && req.cmd == CMD_LOAD_ONSITE
          && {20'd0, req.entry_index} < MAX_SITES)
         onsite_mem[SW'(req.entry_index)] <= req.onsite_value;
      onsite_rdata_ff <= onsite_mem[site_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         site_count_ff <= 6'd32;
         local_count_ff <= '0;
         global_offset_ff <= '0;
         hop_ff <= '0;
         inter_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SITE_COUNT: site_count_ff <= csr_write_data[5:0];
            CSR_LOCAL_COUNT: local_count_ff <= csr_write_data[12:0];
            CSR_GLOBAL_OFFSET: global_offset_ff <= csr_write_data;
            CSR_HOP_AMPLITUDE: hop_ff <= csr_write_data[23:0];
            CSR_INTERACTION: inter_ff <= csr_write_data[23:0];
            default: ;
         endcase
      end
   end

   assign req.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp.valid <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid && req.cmd == CMD_PROCESS && LW'(req.entry_index) < eff_len
                   && {20'd0, req.entry_index} < TABLE_DEPTH + 1) begin
                  len_ff <= eff_len;
                  sites_ff <= eff_sites;
                  col_ff <= global_offset_ff + IndexWidth'(req.entry_index);
                  site_ff <= '0;
                  diag_ff <= '0;
                  state_ff <= ST_ROW_WAIT;
               end
            end
            ST_ROW_READ: state_ff <= ST_SITE;
            ST_ROW_WAIT: begin
               // Keep only the low bits of the ring.
               for (int i = 0; i < WordWidth; i++)
                  word_ff[i] <= mem_rdata_ff[i] && (i < int'(sites_ff));
               state_ff <= ST_SITE;
            end
            ST_SITE: begin
               // Onsite value of the current site comes from a register loaded from site_ff.
               if (b0) diag_ff <= diag_ff + (OutValueWidth+5)'($signed(onsite_rdata_ff))
                  + (b1 ? (OutValueWidth+5)'(inter_ff) : '0);
               if (b0 != b1) begin
                  nw_ff <= word_ff ^ (WordWidth'(1) << site_ff) ^ (WordWidth'(1) << next_site);
                  lo_ff <= '0;
                  srch_ff <= len_ff;
                  found_ff <= 1'b0;
                  state_ff <= ST_PROBE;
               end else if (SCW'(site_ff) + SCW'(1) == sites_ff) begin
                  state_ff <= ST_DIAG;
               end else begin
                  site_ff <= next_site;
                  state_ff <= ST_ROW_READ;
               end
            end
            ST_PROBE: begin
               if (srch_ff == '0) state_ff <= ST_EMIT;
               else begin
                  mid_ff <= mid_c;
                  state_ff <= ST_PROBE_WAIT;
               end
            end
            ST_PROBE_WAIT: state_ff <= ST_CMP;
            ST_CMP: begin
               if (mem_rdata_ff == nw_ff) begin
                  found_ff <= 1'b1;
                  pos_ff <= lo_ff + mid_ff;
                  state_ff <= ST_EMIT;
               end else begin
                  if (mem_rdata_ff < nw_ff) begin
                     lo_ff <= lo_ff + mid_ff + 1'b1;
                     srch_ff <= srch_ff - mid_ff - 1'b1;
                  end else srch_ff <= mid_ff;
                  state_ff <= ST_PROBE;
               end
            end
            ST_EMIT: begin
               if (!rsp.valid || rsp.ready) begin
                  rsp.valid <= 1'b1;
                  rsp.entry_kind <= found_ff ? KIND_LOCAL_HOP : KIND_REMOTE_HOP;
                  rsp.row_index <= found_ff ? global_offset_ff + IndexWidth'(pos_ff) : '0;
                  rsp.col_index <= col_ff;
                  rsp.neighbour_word <= nw_ff;
                  rsp.entry_value <= OutValueWidth'(hop_ff);
                  rsp.last <= 1'b0;
                  if (SCW'(site_ff) + SCW'(1) == sites_ff) state_ff <= ST_DIAG;
                  else begin
                     site_ff <= next_site;
                     state_ff <= ST_ROW_READ;
                  end
               end else if (rsp.ready) rsp.valid <= 1'b0;
            end
            ST_DIAG: begin
               if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
               state_ff <= ST_DIAG_EMIT;
            end
            ST_DIAG_EMIT: begin
               if (!rsp.valid || rsp.ready) begin
                  rsp.valid <= 1'b1;
                  rsp.entry_kind <= KIND_DIAGONAL;
                  rsp.row_index <= col_ff;
                  rsp.col_index <= col_ff;
                  rsp.neighbour_word <= '0;
                  rsp.last <= 1'b1;
                  if (diag_ff > (OutValueWidth+5)'(268435455))
                     rsp.entry_value <= 29'sd268435455;
                  else if (diag_ff < -(OutValueWidth+5)'(268435456))
                     rsp.entry_value <= 29'h1000_0000;
                  else rsp.entry_value <= OutValueWidth'(diag_ff);
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (state_ff != ST_EMIT && state_ff != ST_DIAG && state_ff != ST_DIAG_EMIT
             && rsp.valid && rsp.ready)
            rsp.valid <= 1'b0;
      end
   end
endmodule

// ----- dv/lattice_hamiltonian_row_builder_tb.sv -----
// Testbench for the lattice Hamiltonian row builder: random and directed requests with a scoreboard.
module lattice_hamiltonian_row_builder_tb;
   import lhrb_pkg::*;

   localparam int TableSize = 4096;
   localparam int SiteLimit = 32;
   localparam int StallLimit = 20000;
   localparam int TargetItems = 460;

   typedef struct {
      kind_type kind;
      logic [33:0] row;
      logic [33:0] col;
      logic [31:0] nword;
      logic signed [28:0] value;
      logic last;
   } matrix_entry_type;

   class hamiltonian_scoreboard_type;
      logic [31:0] basis_mem[TableSize];
      logic signed [23:0] onsite_mem[SiteLimit];
      logic [5:0] site_cnt;
      logic [12:0] local_cnt;
      logic [33:0] offset;
      logic signed [23:0] hop;
      logic signed [23:0] coupling;
      matrix_entry_type pending_entries[$];
      int failures;

      function new();
         site_cnt = 6'd32;
         local_cnt = 0;
         offset = 0;
         hop = 0;
         coupling = 0;
         failures = 0;
      endfunction

      function void write_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
         case (idx)
            CSR_SITE_COUNT: site_cnt = data[5:0];
            CSR_LOCAL_COUNT: local_cnt = data[12:0];
            CSR_GLOBAL_OFFSET: offset = data[33:0];
            CSR_HOP_AMPLITUDE: hop = data[23:0];
            CSR_INTERACTION: coupling = data[23:0];
            default: ;
         endcase
      endfunction

      // Halving search, so duplicates resolve to the first entry the probes meet.
      function bit find_word(int len, logic [31:0] word, output int pos);
         int lo;
         int mid;
         lo = 0;
         pos = 0;
         while (len != 0) begin
            mid = len / 2;
            if (basis_mem[lo + mid] == word) begin
               pos = lo + mid;
               return 1;
            end
            if (basis_mem[lo + mid] < word) begin
               lo += mid + 1;
               len -= mid + 1;
            end else begin
               len = mid;
            end
         end
         return 0;
      endfunction

      function void note_request(cmd_type cmd, logic [11:0] idx, logic [31:0] word,
            logic signed [23:0] onsite);
         int len;
         int sites;
         int nx;
         int pos;
         logic [31:0] w;
         logic [31:0] nw;
         logic [33:0] col;
         longint diag;
         matrix_entry_type e;
         case (cmd)
            CMD_LOAD_WORD: basis_mem[idx] = word;
            CMD_LOAD_ONSITE: if (idx < SiteLimit) onsite_mem[idx] = onsite;
            CMD_PROCESS: begin
               len = (local_cnt > TableSize) ? TableSize : local_cnt;
               if (idx < len) begin
                  sites = (site_cnt < 2) ? 2 : site_cnt;
                  if (sites > SiteLimit) sites = SiteLimit;
                  w = basis_mem[idx];
                  if (sites < 32) w &= (32'd1 << sites) - 32'd1;
                  col = offset + 34'(idx);
                  diag = 0;
                  for (int s = 0; s < sites; s++) begin
                     nx = (s + 1 == sites) ? 0 : s + 1;
                     if (w[s]) begin
                        diag += longint'(onsite_mem[s]);
                        if (w[nx]) diag += longint'(coupling);
                     end
                     if (w[s] != w[nx]) begin
                        nw = w ^ (32'd1 << s) ^ (32'd1 << nx);
                        e.col = col;
                        e.nword = nw;
                        e.value = 29'(hop);
                        e.last = 1'b0;
                        if (find_word(len, nw, pos)) begin
                           e.kind = KIND_LOCAL_HOP;
                           e.row = offset + 34'(pos);
                        end else begin
                           e.kind = KIND_REMOTE_HOP;
                           e.row = '0;
                        end
                        pending_entries.insert(pending_entries.size(), e);
                     end
                  end
                  if (diag > 64'sd268435455) diag = 64'sd268435455;
                  if (diag < -64'sd268435456) diag = -64'sd268435456;
                  e.kind = KIND_DIAGONAL;
                  e.row = col;
                  e.col = col;
                  e.nword = '0;
                  e.value = diag[28:0];
                  e.last = 1'b1;
                  pending_entries.insert(pending_entries.size(), e);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [1:0] kind, logic [33:0] row, logic [33:0] col,
            logic [31:0] nword, logic [28:0] value, logic last);
         matrix_entry_type e;
         if (pending_entries.size() == 0) begin
            $error("unexpected result: kind %0d row %0h col %0h", kind, row, col);
            failures++;
            return;
         end
         e = pending_entries.pop_front();
         if (kind !== e.kind) begin
            $error("entry_kind: expected %0d, got %0d", e.kind, kind);
            failures++;
         end
         if (row !== e.row) begin
            $error("row_index: expected %0h, got %0h", e.row, row);
            failures++;
         end
         if (col !== e.col) begin
            $error("col_index: expected %0h, got %0h", e.col, col);
            failures++;
         end
         if (nword !== e.nword) begin
            $error("neighbour_word: expected %0h, got %0h", e.nword, nword);
            failures++;
         end
         if (value !== e.value) begin
            $error("entry_value: expected %0h, got %0h", e.value, value);
            failures++;
         end
         if (last !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, last);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_write_data;

   lhrb_req_if req_ch();
   lhrb_rsp_if rsp_ch();

   lattice_hamiltonian_row_builder DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   hamiltonian_scoreboard_type sb = new();
   int request_count = 0;
   int quiet_cycles = 0;
   bit calm = 0;
   bit hold_request = 0;
   int hold_left = 0;
   logic [31:0] table_words[$];

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.entry_kind, rsp_ch.row_index, rsp_ch.col_index,
            rsp_ch.neighbour_word, rsp_ch.entry_value, rsp_ch.last);
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_write_enable)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Response side: random back-pressure, plus one long hold-off on request.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = 3000;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready = calm || ($urandom_range(99) >= 8);
         end
      end
   end

   task automatic send(cmd_type cmd, logic [11:0] idx, logic [31:0] word,
         logic signed [23:0] onsite);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 8) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.cmd = cmd;
      req_ch.entry_index = idx;
      req_ch.basis_word = word;
      req_ch.onsite_value = onsite;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sb.note_request(cmd, idx, word, onsite);
      request_count++;
   endtask

   task automatic write_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
      @(negedge clock);
      req_ch.valid = 1'b0;
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.write_reg(idx, data);
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (sb.pending_entries.size() != 0) @(posedge clock);
      // Rows outside the table give nothing but may still be in flight.
      repeat (100) @(posedge clock);
   endtask

   // onsite_mode: 0 a few random sites, 1 all random, 2 all at maximum, 3 all at minimum.
   task automatic run_phase(logic [5:0] sites_reg, logic [12:0] len_reg, logic [33:0] offs,
         logic [23:0] hop, logic [23:0] coup, int onsite_mode, int extra);
      int eff_sites;
      int len;
      int r;
      logic [31:0] mask;
      logic signed [23:0] ov;
      drain();
      write_reg(CSR_SITE_COUNT, 34'(sites_reg));
      write_reg(CSR_LOCAL_COUNT, 34'(len_reg));
      write_reg(CSR_GLOBAL_OFFSET, offs);
      write_reg(CSR_HOP_AMPLITUDE, 34'(hop));
      write_reg(CSR_INTERACTION, 34'(coup));
      eff_sites = (sites_reg < 2) ? 2 : ((sites_reg > SiteLimit) ? SiteLimit : sites_reg);
      mask = (eff_sites == 32) ? 32'hFFFF_FFFF : ((32'd1 << eff_sites) - 32'd1);
      len = (len_reg > TableSize) ? TableSize : len_reg;
      for (int s = 0; s < SiteLimit; s++) begin
         case (onsite_mode)
            1: ov = 24'($urandom);
            2: ov = 24'sh7FFFFF;
            3: ov = -24'sh800000;
            default: ov = 24'($urandom);
         endcase
         if (onsite_mode != 0 || $urandom_range(7) == 0)
            send(CMD_LOAD_ONSITE, 12'(s), $urandom, ov);
      end
      table_words.delete();
      for (int i = 0; i < len; i++)
         table_words.insert(table_words.size(),
            ($urandom_range(7) == 0) ? $urandom : ($urandom & mask));
      // The all-ones word makes every pair occupied, which drives the diagonal to saturate.
      if (onsite_mode >= 2 && len > 0) table_words[0] = 32'hFFFF_FFFF;
      table_words.sort();
      for (int i = 0; i < len; i++)
         send(CMD_LOAD_WORD, 12'(i), table_words[i], 24'($urandom));
      for (int i = 0; i < len; i++)
         send(CMD_PROCESS, 12'(i), $urandom, 24'($urandom));
      for (int i = 0; i < extra; i++) begin
         r = $urandom_range(99);
         if (r < 70 && len > 0)
            send(CMD_PROCESS, 12'($urandom_range(len - 1)), $urandom, 24'($urandom));
         else if (r < 78)
            send(CMD_PROCESS, 12'($urandom_range(4095, len)), $urandom, 24'($urandom));
         else if (r < 86)
            send(CMD_LOAD_WORD, 12'($urandom_range(4095, len)), $urandom, 24'($urandom));
         else if (r < 93)
            send(CMD_LOAD_ONSITE, 12'($urandom_range(4095)), $urandom, 24'($urandom));
         else
            send(CMD_UNUSED, 12'($urandom), $urandom, 24'($urandom));
      end
   endtask

   initial begin
      int phase;
      logic [5:0] sites_reg;
      logic [12:0] len_reg;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_LOAD_WORD;
      req_ch.entry_index = '0;
      req_ch.basis_word = '0;
      req_ch.onsite_value = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: two sites with a wrapping offset, then both saturation directions,
      // then a site count below range with an empty table.
      run_phase(6'd2, 13'd4, 34'h3_FFFF_FFFE, 24'h7FFFFF, 24'h800000, 1, 4);
      run_phase(6'd32, 13'd3, 34'h0, 24'h800000, 24'h7FFFFF, 2, 0);
      run_phase(6'd63, 13'd3, 34'h3_FFFF_FFFF, 24'h000001, 24'h800000, 3, 0);
      run_phase(6'd0, 13'd0, 34'h1, 24'h123456, 24'h654321, 0, 4);

      phase = 0;
      while (request_count < TargetItems) begin
         case ($urandom_range(9))
            0: sites_reg = 6'd32;
            1: sites_reg = 6'($urandom_range(63, 33));
            2: sites_reg = 6'd0;
            3: sites_reg = 6'($urandom_range(31, 9));
            default: sites_reg = 6'($urandom_range(8, 2));
         endcase
         case ($urandom_range(9))
            0: len_reg = 13'($urandom_range(200, 100));
            1: len_reg = 13'd1;
            default: len_reg = 13'($urandom_range(40, 2));
         endcase
         // Keep the last table small so the request total stays near the target.
         if (int'(len_reg) > (TargetItems - request_count) / 2)
            len_reg = 13'((TargetItems - request_count) / 2 + 1);
         run_phase(sites_reg, len_reg, {$urandom, 2'($urandom)}, 24'($urandom),
            24'($urandom), 0, $urandom_range(30, 15));
         phase++;
         if (phase == 2) begin
            calm = 1;
            hold_request = 1;
         end else begin
            calm = (phase == 4);
         end
      end

      drain();
      calm = 0;
      repeat (500) @(posedge clock);
      if (sb.failures == 0 && sb.pending_entries.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
